// File: design/mcfd_pkg.sv
package mcfd_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 40;

  localparam int unsigned CHAN_W   = 6;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned FADE_W   = 16;
  localparam int unsigned DUTY_W   = 12;
  localparam int unsigned FPS_W    = 7;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned DIV_W    = 16;
  localparam int unsigned DVSR_W   = 8;
  localparam int unsigned DCNT_W   = 5;

  localparam logic [DCNT_W-1:0] DIV_LONG_STEPS  = DCNT_W'(DIV_W);
  localparam logic [DCNT_W-1:0] DIV_SHORT_STEPS = DCNT_W'(LEVEL_W);

  localparam logic [DIV_W-1:0]   FRAME_MS_BASE   = DIV_W'(1000);
  localparam logic [LEVEL_W-1:0] SNAP_LEVEL      = LEVEL_W'(4);
  localparam logic [LEVEL_W-1:0] LIMIT_RESET     = LEVEL_W'(100);
  localparam logic [FPS_W-1:0]   FPS_RESET       = FPS_W'(20);

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_FPS        = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] target;
    logic [FADE_W-1:0]  fade;
  } chan_state_t;

  typedef struct packed {
    logic        level_we;
    logic        ctl_we;
    chan_state_t entry;
  } store_wr_t;

  typedef struct packed {
    logic              start;
    logic              short_op;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/mcfd_div.sv
module mcfd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcfd_pkg::div_req_t  req_i,
  output mcfd_pkg::div_rsp_t  rsp_o
);

  logic [mcfd_pkg::DIV_W-1:0]  quo_q;
  logic [mcfd_pkg::DVSR_W-1:0] rem_q;
  logic [mcfd_pkg::DVSR_W-1:0] dvsr_q;
  logic [mcfd_pkg::DCNT_W-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [mcfd_pkg::DVSR_W:0]   trial;
  logic                        fits;
  logic [mcfd_pkg::DVSR_W-1:0] rem_d;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[mcfd_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvsr_q};
  assign rem_d = fits ? mcfd_pkg::DVSR_W'(trial - {1'b0, dvsr_q})
                      : trial[mcfd_pkg::DVSR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvsr_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        // a short divide only runs over the low byte of the dividend
        quo_q  <= req_i.short_op ? {req_i.dividend[mcfd_pkg::LEVEL_W-1:0],
                                    {(mcfd_pkg::DIV_W-mcfd_pkg::LEVEL_W){1'b0}}}
                                 : req_i.dividend;
        cnt_q  <= req_i.short_op ? mcfd_pkg::DIV_SHORT_STEPS : mcfd_pkg::DIV_LONG_STEPS;
        rem_q  <= '0;
        dvsr_q <= req_i.divisor;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[mcfd_pkg::DIV_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mcfd_pkg::DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: design/mcfd_store.sv
module mcfd_store #(
  parameter int unsigned NumChannels = mcfd_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned IdxW        = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  output mcfd_pkg::chan_state_t rd_entry_o,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  mcfd_pkg::store_wr_t   wr_i
);

  localparam int unsigned CtlW = mcfd_pkg::LEVEL_W + mcfd_pkg::FADE_W;

  logic [mcfd_pkg::LEVEL_W-1:0] level_mem [NumChannels];
  logic [CtlW-1:0]              ctl_mem   [NumChannels];

  logic [NumChannels-1:0]       level_vld_q;
  logic [NumChannels-1:0]       ctl_vld_q;

  logic [mcfd_pkg::LEVEL_W-1:0] level_rd_q;
  logic [CtlW-1:0]              ctl_rd_q;
  logic                         level_rd_vld_q;
  logic                         ctl_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.level_we) begin
      level_mem[wr_addr_i] <= wr_i.entry.level;
    end
    if (wr_i.ctl_we) begin
      ctl_mem[wr_addr_i] <= {wr_i.entry.target, wr_i.entry.fade};
    end
    if (rd_en_i) begin
      level_rd_q <= level_mem[rd_addr_i];
      ctl_rd_q   <= ctl_mem[rd_addr_i];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_vld_q    <= '0;
      ctl_vld_q      <= '0;
      level_rd_vld_q <= 1'b0;
      ctl_rd_vld_q   <= 1'b0;
    end else begin
      if (wr_i.level_we) begin
        level_vld_q[wr_addr_i] <= 1'b1;
      end
      if (wr_i.ctl_we) begin
        ctl_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        level_rd_vld_q <= level_vld_q[rd_addr_i];
        ctl_rd_vld_q   <= ctl_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o.level = level_rd_vld_q ? level_rd_q : '0;
  assign {rd_entry_o.target, rd_entry_o.fade} = ctl_rd_vld_q ? ctl_rd_q : '0;

endmodule

// File: design/multi_channel_fade_dimmer.sv
// A set command writes the channel store as it is accepted. A tick first runs
// a 16-step divide to find the frame period; then each channel either jumps or,
// when it fades, runs a 16-step and an 8-step divide on the shared one-bit-per-cycle
// divider. Throughput: one item at a time; an output stall holds the frame up.
// Reset clears all levels, targets and fade times at once through per-entry valid
// bits; brightness_limit returns to 100 and frames_per_second to 20.
module multi_channel_fade_dimmer #(
  parameter int unsigned NUM_CHANNELS = mcfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [mcfd_pkg::LEVEL_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [mcfd_pkg::CHAN_W-1:0]    channel_i,
  input  logic [mcfd_pkg::LEVEL_W-1:0]   target_level_i,
  input  logic [mcfd_pkg::FADE_W-1:0]    fade_ms_i,
  input  logic [mcfd_pkg::FADE_W-1:0]    elapsed_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mcfd_pkg::CHAN_W-1:0]    out_channel_o,
  output logic [mcfd_pkg::LEVEL_W-1:0]   drive_level_o,
  output logic [mcfd_pkg::DUTY_W-1:0]    duty_twelve_o,
  output logic [mcfd_pkg::LEVEL_W-1:0]   current_level_o,
  output logic                           last_of_frame_o
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned LW   = mcfd_pkg::LEVEL_W;
  localparam int unsigned FW   = mcfd_pkg::FADE_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PERIOD, ST_READ, ST_FETCH, ST_STEPS, ST_DELTA, ST_SQUARE, ST_EMIT
  } state_e;

  state_e state_q;

  logic [LW-1:0]                 limit_q;
  logic [mcfd_pkg::FPS_W-1:0]    fps_q;
  logic [mcfd_pkg::DVSR_W-1:0]   fps_eff;

  logic [FW-1:0]                 elapsed_q;
  logic [mcfd_pkg::PERIOD_W-1:0] period_q;
  logic [IdxW-1:0]               ch_q;
  logic [LW-1:0]                 lvl_q;
  logic [LW-1:0]                 tgt_q;
  logic [FW-1:0]                 fade_q;
  logic [2*LW-1:0]               sq_q;

  logic                          out_valid_q;
  logic [mcfd_pkg::CHAN_W-1:0]   out_channel_q;
  logic [LW-1:0]                 drive_q;
  logic [mcfd_pkg::DUTY_W-1:0]   duty_q;
  logic [LW-1:0]                 cur_q;
  logic                          last_q;

  mcfd_pkg::div_req_t            div_req_q;
  mcfd_pkg::div_rsp_t            div_rsp;
  mcfd_pkg::chan_state_t         rd_entry;
  mcfd_pkg::store_wr_t           wr_req;
  logic [IdxW-1:0]               wr_addr;

  logic                          in_accept;
  logic                          set_hit;
  logic                          emit_go;
  logic                          ch_last;
  logic [LW-1:0]                 steps;
  logic [LW-1:0]                 diff;
  logic [2*LW:0]                 sq_adj;
  logic [LW-1:0]                 sq_div;
  logic [LW-1:0]                 drive_d;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mcfd_pkg::LIMIT_RESET;
      fps_q   <= mcfd_pkg::FPS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == mcfd_pkg::REG_BRIGHTNESS) begin
        limit_q <= cfg_data_i;
      end else if (cfg_index_i == mcfd_pkg::REG_FPS) begin
        fps_q <= cfg_data_i[mcfd_pkg::FPS_W-1:0];
      end
    end
  end

  assign fps_eff = (fps_q == '0) ? mcfd_pkg::DVSR_W'(1) : mcfd_pkg::DVSR_W'(fps_q);

  // ---------------------------------------------------------------- datapath
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign set_hit    = in_accept && (operation_i == mcfd_pkg::OP_SET) &&
                      (7'(channel_i) < 7'(NUM_CHANNELS));
  assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign ch_last    = (ch_q == IdxW'(NUM_CHANNELS - 1));

  // step count saturates at 255 and never drops to zero
  assign steps = (div_rsp.quotient > mcfd_pkg::DIV_W'(255)) ? LW'(255) :
                 (div_rsp.quotient == '0) ? LW'(1) : div_rsp.quotient[LW-1:0];
  assign diff  = (tgt_q > lvl_q) ? LW'(tgt_q - lvl_q) : LW'(lvl_q - tgt_q);

  // floor(x/255) for a 16-bit square
  assign sq_adj  = (2*LW+1)'(sq_q) + (2*LW+1)'(sq_q[2*LW-1:LW]) + (2*LW+1)'(1);
  assign sq_div  = sq_adj[2*LW-1:LW];
  assign drive_d = (sq_div > limit_q) ? limit_q : sq_div;

  always_comb begin
    wr_req          = '0;
    wr_addr         = ch_q;
    if (set_hit) begin
      wr_req.ctl_we       = 1'b1;
      wr_req.entry.target = target_level_i;
      wr_req.entry.fade   = fade_ms_i;
      wr_addr             = channel_i[IdxW-1:0];
    end else if (emit_go) begin
      wr_req.level_we     = 1'b1;
      wr_req.ctl_we       = 1'b1;
      wr_req.entry.level  = lvl_q;
      wr_req.entry.target = tgt_q;
      wr_req.entry.fade   = fade_q;
    end
  end

  mcfd_store #(
    .NumChannels (NUM_CHANNELS),
    .IdxW        (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (state_q == ST_READ),
    .rd_addr_i  (ch_q),
    .rd_entry_o (rd_entry),
    .wr_addr_i  (wr_addr),
    .wr_i       (wr_req)
  );

  mcfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      div_req_q     <= '0;
      elapsed_q     <= '0;
      period_q      <= '0;
      ch_q          <= '0;
      lvl_q         <= '0;
      tgt_q         <= '0;
      fade_q        <= '0;
      sq_q          <= '0;
      out_valid_q   <= 1'b0;
      out_channel_q <= '0;
      drive_q       <= '0;
      duty_q        <= '0;
      cur_q         <= '0;
      last_q        <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept && (operation_i == mcfd_pkg::OP_TICK)) begin
            elapsed_q          <= elapsed_ms_i;
            div_req_q.start    <= 1'b1;
            div_req_q.short_op <= 1'b0;
            div_req_q.dividend <= mcfd_pkg::FRAME_MS_BASE;
            div_req_q.divisor  <= fps_eff;
            state_q            <= ST_PERIOD;
          end
        end
        ST_PERIOD: begin
          if (div_rsp.done) begin
            period_q <= div_rsp.quotient[mcfd_pkg::PERIOD_W-1:0];
            ch_q     <= '0;
            // drop a short tick
            if (elapsed_q < FW'(div_rsp.quotient[mcfd_pkg::PERIOD_W-1:0])) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          tgt_q  <= rd_entry.target;
          fade_q <= rd_entry.fade;
          if (rd_entry.fade == '0) begin
            lvl_q   <= rd_entry.target;
            state_q <= ST_SQUARE;
          end else begin
            lvl_q              <= rd_entry.level;
            div_req_q.start    <= 1'b1;
            div_req_q.short_op <= 1'b0;
            div_req_q.dividend <= rd_entry.fade;
            div_req_q.divisor  <= fps_eff;
            state_q            <= ST_STEPS;
          end
        end
        ST_STEPS: begin
          if (div_rsp.done) begin
            div_req_q.start    <= 1'b1;
            div_req_q.short_op <= 1'b1;
            div_req_q.dividend <= mcfd_pkg::DIV_W'(diff);
            div_req_q.divisor  <= steps;
            if (17'(fade_q) < (17'(elapsed_q) + 17'(period_q))) begin
              fade_q <= '0;
            end else begin
              fade_q <= fade_q - elapsed_q;
            end
            state_q <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          if (div_rsp.done) begin
            if (tgt_q > lvl_q) begin
              lvl_q <= lvl_q + div_rsp.quotient[LW-1:0];
            end else if (tgt_q < lvl_q) begin
              lvl_q <= lvl_q - div_rsp.quotient[LW-1:0];
            end
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          // snap dim levels to off, target too
          if (lvl_q <= mcfd_pkg::SNAP_LEVEL) begin
            lvl_q <= '0;
            tgt_q <= '0;
            sq_q  <= '0;
          end else begin
            sq_q <= (2*LW)'(lvl_q) * (2*LW)'(lvl_q);
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_q   <= 1'b1;
            out_channel_q <= mcfd_pkg::CHAN_W'(ch_q);
            drive_q       <= drive_d;
            duty_q        <= {lvl_q, lvl_q[LW-1:LW/2]};
            cur_q         <= lvl_q;
            last_q        <= ch_last;
            if (ch_last) begin
              state_q <= ST_IDLE;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = out_channel_q;
  assign drive_level_o   = drive_q;
  assign duty_twelve_o   = duty_q;
  assign current_level_o = cur_q;
  assign last_of_frame_o = last_q;

endmodule

// File: tb/sv/multi_channel_fade_dimmer_tb.sv
`timescale 1ns / 100ps

module multi_channel_fade_dimmer_tb;
  import mcfd_pkg::*;

  localparam int unsigned NCH = NUM_CHANNELS_DEF;
  // a short tick or a set command may still be in flight once the last result is in
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] drive;
    logic [DUTY_W-1:0]  duty;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } chan_output_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = REG_BRIGHTNESS;
  logic [LEVEL_W-1:0]  cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                operation_i = OP_SET;
  logic [CHAN_W-1:0]   channel_i = '0;
  logic [LEVEL_W-1:0]  target_level_i = '0;
  logic [FADE_W-1:0]   fade_ms_i = '0;
  logic [FADE_W-1:0]   elapsed_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CHAN_W-1:0]   out_channel_o;
  logic [LEVEL_W-1:0]  drive_level_o;
  logic [DUTY_W-1:0]   duty_twelve_o;
  logic [LEVEL_W-1:0]  current_level_o;
  logic                last_of_frame_o;

  // predicted dimmer state
  logic [LEVEL_W-1:0] dim_level  [NCH];
  logic [LEVEL_W-1:0] dim_target [NCH];
  logic [FADE_W-1:0]  dim_fade   [NCH];
  logic [LEVEL_W-1:0] dim_limit;
  logic [FPS_W-1:0]   dim_fps;

  chan_output_t due_outputs[$];
  int           mismatch_count = 0;
  int unsigned  burst_left = 0;
  logic [15:0]  ready_pattern = '1;
  int unsigned  stall_cycles = 0;

  multi_channel_fade_dimmer i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic reset_dimmer();
    for (int c = 0; c < NCH; c++) begin
      dim_level[c]  = '0;
      dim_target[c] = '0;
      dim_fade[c]   = '0;
    end
    dim_limit = LIMIT_RESET;
    dim_fps   = FPS_RESET;
  endtask

  // Update the predicted channels for one accepted transaction and queue the outputs
  // that a frame produces.
  task automatic apply_item(input logic op, input logic [CHAN_W-1:0] ch,
                            input logic [LEVEL_W-1:0] tgt, input logic [FADE_W-1:0] fade_ms,
                            input logic [FADE_W-1:0] elapsed);
    int unsigned  fps, period, steps, lvl, goal, remain, sq;
    chan_output_t res;
    fps = (dim_fps == '0) ? 1 : dim_fps;
    period = FRAME_MS_BASE / fps;
    if (op == OP_SET) begin
      if (ch < NCH) begin
        dim_target[ch] = tgt;
        dim_fade[ch]   = fade_ms;
      end
    end else if (elapsed >= period) begin
      for (int c = 0; c < NCH; c++) begin
        lvl    = dim_level[c];
        goal   = dim_target[c];
        remain = dim_fade[c];
        if (remain == 0) begin
          lvl = goal;
        end else begin
          steps = remain / fps;
          if (steps > 255) steps = 255;
          if (steps == 0) steps = 1;
          if (goal > lvl) lvl = lvl + (goal - lvl) / steps;
          else if (goal < lvl) lvl = lvl - (lvl - goal) / steps;
          remain = (remain < elapsed + period) ? 0 : remain - elapsed;
        end
        if (lvl <= SNAP_LEVEL) begin
          lvl  = 0;
          goal = 0;
        end
        dim_level[c]  = LEVEL_W'(lvl);
        dim_target[c] = LEVEL_W'(goal);
        dim_fade[c]   = FADE_W'(remain);
        sq = (lvl * lvl) / 255;
        if (sq > dim_limit) sq = dim_limit;
        res.channel = CHAN_W'(c);
        res.drive   = LEVEL_W'(sq);
        res.duty    = {dim_level[c], dim_level[c][LEVEL_W-1:4]};
        res.level   = dim_level[c];
        res.last    = (c == NCH - 1);
        due_outputs.push_back(res);
      end
    end
  endtask

  task automatic send_item(input logic op, input logic [CHAN_W-1:0] ch,
                           input logic [LEVEL_W-1:0] tgt, input logic [FADE_W-1:0] fade_ms,
                           input logic [FADE_W-1:0] elapsed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    channel_i      <= ch;
    target_level_i <= tgt;
    fade_ms_i      <= fade_ms;
    elapsed_ms_i   <= elapsed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_item(op, ch, tgt, fade_ms, elapsed);
  endtask

  task automatic send_set(input int unsigned ch, input int unsigned tgt,
                          input int unsigned fade_ms);
    send_item(OP_SET, CHAN_W'(ch), LEVEL_W'(tgt), FADE_W'(fade_ms), FADE_W'($urandom));
  endtask

  task automatic send_tick(input int unsigned elapsed);
    send_item(OP_TICK, CHAN_W'($urandom), LEVEL_W'($urandom), FADE_W'($urandom),
              FADE_W'(elapsed));
  endtask

  // Drop valid and hold until every queued output has been taken.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [LEVEL_W-1:0] limit, input logic [FPS_W-1:0] fps);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_BRIGHTNESS;
    cfg_data_i  <= limit;
    @(posedge clk_i);
    cfg_index_i <= REG_FPS;
    cfg_data_i  <= {1'b0, fps};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dim_limit = limit;
    dim_fps   = fps;
  endtask

  task automatic test_reset_state();
    send_tick(49);
    send_tick(50);
  endtask

  task automatic test_jump();
    send_set(0, 255, 0);
    send_set(NCH - 1, 128, 0);
    send_set(5, 4, 0);
    send_set(6, 5, 0);
    send_tick(16'hFFFF);
  endtask

  task automatic test_channel_range();
    send_set(NCH, 200, 0);
    send_set(63, 255, 16'hFFFF);
    send_tick(75);
  endtask

  task automatic test_fade();
    send_set(0, 0, 16'hFFFF);
    send_set(1, 200, 30);
    send_set(2, 100, 10);
    send_set(3, 170, 1000);
    send_tick(50);
    send_tick(60);
    send_tick(1000);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    // zero frame rate runs as one frame per second
    set_config(8'd0, 7'd0);
    send_set(4, 255, 0);
    send_tick(999);
    send_tick(1000);
    wait_idle();
    set_config(8'd255, 7'd127);
    send_set(8, 250, 2000);
    send_tick(7);
    send_tick(6);
    wait_idle();
    set_config(8'd200, 7'd100);
    send_tick(10);
    wait_idle();
    set_config(LIMIT_RESET, 7'd1);
    send_tick(1000);
  endtask

  task automatic test_random();
    int unsigned period, pick, fade_ms;
    logic [LEVEL_W-1:0] limit;
    logic [FPS_W-1:0]   fps;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      pick = $urandom_range(0, 5);
      limit = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : LEVEL_W'($urandom);
      pick = $urandom_range(0, 7);
      case (pick)
        0: fps = 7'd0;
        1: fps = 7'd127;
        2: fps = 7'd100;
        3: fps = 7'd1;
        default: fps = FPS_W'($urandom_range(2, 100));
      endcase
      set_config(limit, fps);
      period = FRAME_MS_BASE / ((dim_fps == '0) ? 1 : dim_fps);
      for (int n = 0; n < 14; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          case ($urandom_range(0, 9))
            0, 1, 2: fade_ms = 0;
            8:       fade_ms = $urandom_range(0, 16'hFFFF);
            9:       fade_ms = 16'hFFFF;
            default: fade_ms = $urandom_range(1, 20 * period);
          endcase
          if (pick < 50)
            send_set($urandom_range(0, NCH - 1),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 255),
                     fade_ms);
          else
            send_set($urandom_range(NCH, 63), $urandom_range(0, 255), fade_ms);
        end else if (pick < 92) begin
          if ($urandom_range(0, 8) == 0) send_tick($urandom_range(period, 16'hFFFF));
          else send_tick($urandom_range(period, 3 * period));
        end else begin
          send_tick($urandom_range(0, period - 1));
        end
      end
    end
  endtask

  // receiver: rotate a stall pattern, pick a new one now and then
  always @(posedge clk_i) begin
    if (stall_cycles == 0) begin
      stall_cycles  <= $urandom_range(50, 300);
      ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      stall_cycles  <= stall_cycles - 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    out_ready_i <= ready_pattern[0];
  end

  always @(posedge clk_i) begin
    chan_output_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction for channel %0d", out_channel_o));
      end else begin
        want = due_outputs.pop_front();
        if (out_channel_o !== want.channel)
          report_mismatch($sformatf("out_channel: expected %0d, got %0d",
                                    want.channel, out_channel_o));
        if (drive_level_o !== want.drive)
          report_mismatch($sformatf("ch %0d drive_level: expected %0d, got %0d",
                                    want.channel, want.drive, drive_level_o));
        if (duty_twelve_o !== want.duty)
          report_mismatch($sformatf("ch %0d duty_twelve: expected %0h, got %0h",
                                    want.channel, want.duty, duty_twelve_o));
        if (current_level_o !== want.level)
          report_mismatch($sformatf("ch %0d current_level: expected %0d, got %0d",
                                    want.channel, want.level, current_level_o));
        if (last_of_frame_o !== want.last)
          report_mismatch($sformatf("ch %0d last_of_frame: expected %0b, got %0b",
                                    want.channel, want.last, last_of_frame_o));
      end
    end
  end

  initial begin
    reset_dimmer();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_jump();
    test_channel_range();
    test_fade();
    test_config_extremes();
    test_random();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("multi_channel_fade_dimmer regression: pass");
    end else begin
      $display("multi_channel_fade_dimmer regression: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("multi_channel_fade_dimmer regression: fail");
    $finish;
  end

endmodule
